### sv/tgpg_pkg.sv
// Shared types, widths, codes and helper functions of the tensor grid point gather.
// No dependencies; every other file of the block imports this package.

package tgpg_pkg;

   // Fixed field widths of the item and result channels.
   localparam int HwDims    = 4;
   localparam int ModeW     = 2;
   localparam int LinearW   = 32;
   localparam int LocalW    = 8;
   localparam int NodeAddrW = 10;
   localparam int CoordW    = 64;
   localparam int DimW      = 2;

   // Configuration register widths and port geometry.
   localparam int DimCntW   = 3;
   localparam int PointsW   = 9;
   localparam int CsrAddrW  = 5;
   localparam int CsrDataW  = 32;

   // Limits of the grid description.
   localparam int MaxDims         = 4;
   localparam int MaxPointsPerDim = 256;
   localparam int DimsCap   = (MaxDims < HwDims) ? MaxDims : HwDims;
   localparam int PointsMax = (1 << PointsW) - 1;
   localparam int PointsCap = (MaxPointsPerDim > PointsMax) ? PointsMax : MaxPointsPerDim;
   localparam logic [PointsW-1:0] PointsCapW = PointsW'(PointsCap);
   localparam logic [DimCntW-1:0] DimsCapW   = DimCntW'(DimsCap);

   // Running table offset: three dimensions of at most PointsMax points plus a local index.
   localparam int OffsetW   = 12;

   // Shared serial divider geometry.
   localparam int DividendW = 32;
   localparam int DivisorW  = 17;
   localparam int DivCountW = $clog2(DividendW);

   typedef enum logic [ModeW-1:0] {
      MODE_WRITE  = 2'd0,
      MODE_LINEAR = 2'd1,
      MODE_MULTI  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_DIMS    = 3'd0,
      REG_POINTS0 = 3'd1,
      REG_POINTS1 = 3'd2,
      REG_POINTS2 = 3'd3,
      REG_POINTS3 = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic                 start;
      logic [DividendW-1:0] dividend;
      logic [DivisorW-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DividendW-1:0] quotient;
      logic [DivisorW-1:0]  remainder;
   } div_status_type;

   // A point count of zero means one point; counts above the cap saturate.
   function automatic logic [PointsW-1:0] eff_points(input logic [PointsW-1:0] raw);
      logic [PointsW-1:0] p;
      p = raw;
      if (p == '0) p = PointsW'(1);
      if (p > PointsCapW) p = PointsCapW;
      return p;
   endfunction

   // A dimension count of zero means one; counts above the cap saturate.
   function automatic logic [DimCntW-1:0] eff_dims(input logic [DimCntW-1:0] raw);
      logic [DimCntW-1:0] d;
      d = raw;
      if (d == '0) d = DimCntW'(1);
      if (d > DimsCapW) d = DimsCapW;
      return d;
   endfunction

endpackage

### sv/tgpg_if.sv
// Valid/ready channel interfaces for the item input and the result output.
// Depends on tgpg_pkg for field widths.

interface tgpg_req_if import tgpg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ModeW-1:0]     mode;
   logic [LinearW-1:0]   linear_index;
   logic [LocalW-1:0]    index_dim0;
   logic [LocalW-1:0]    index_dim1;
   logic [LocalW-1:0]    index_dim2;
   logic [LocalW-1:0]    index_dim3;
   logic [NodeAddrW-1:0] node_address;
   logic [CoordW-1:0]    node_value;

   modport source (
      output valid, mode, linear_index, index_dim0, index_dim1, index_dim2, index_dim3,
             node_address, node_value,
      input  ready
   );
   modport sink (
      input  valid, mode, linear_index, index_dim0, index_dim1, index_dim2, index_dim3,
             node_address, node_value,
      output ready
   );
endinterface

interface tgpg_rsp_if import tgpg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DimW-1:0]   dimension;
   logic [CoordW-1:0] coordinate;
   logic [LocalW-1:0] local_index;
   logic              error;
   logic              last;

   modport source (
      output valid, dimension, coordinate, local_index, error, last,
      input  ready
   );
   modport sink (
      input  valid, dimension, coordinate, local_index, error, last,
      output ready
   );
endinterface

### sv/tgpg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tgpg_pkg for operand widths and the request/status structs.

module tgpg_div import tgpg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  div_req_type    req,
   output div_status_type status
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DivCountW-1:0] cnt_ff, cnt_in;
   logic [DividendW-1:0] quo_ff, quo_in;
   logic [DivisorW-1:0]  rem_ff, rem_in;
   logic [DivisorW-1:0]  dsr_ff, dsr_in;
   logic [DivisorW:0]    trial;
   logic [DivisorW:0]    diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DividendW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DividendW-2:0], fits};
         rem_in = fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
         cnt_in = cnt_ff + DivCountW'(1);
         if (cnt_ff == DivCountW'(DividendW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

endmodule

### sv/tensor_grid_point_gather.sv
// Top level of the tensor grid point gather: config registers, node table and sequencer.
// Depends on tgpg_pkg, the channel interfaces in tgpg_if and the divider tgpg_div.
//
// The req channel carries items of three kinds. A write item stores one 64-bit node
// word into the node table in the cycle it is accepted, if its address lies below
// NODE_DEPTH, and produces no result. A linear lookup splits its flat index into one
// local index per dimension, dimension zero least significant, and a multiindex
// lookup takes the local indices directly. Either lookup then returns one result per
// dimension on the rsp channel, the last one flagged; an index outside the grid
// returns a single error result instead. A write or unused item finishes at once
// and req stays ready. A linear lookup passes each dimension through the shared
// serial divider, which sets the pace. Each result then takes a table read and an
// output load, preceded by a pass through the same divider to reduce the table
// address when NODE_DEPTH is not a power of two. A multiindex lookup starts
// producing results right away. Lookups are handled one at a time and req is not
// ready until the last result is in the output register. Reset clears the
// sequencer, the output valid and all config registers to one; the node table
// contents stay undefined until written, so no clearing pass is run. When the
// receiver stalls, the waiting result holds in the output register and the
// sequencer pauses before loading the next one. The CSR port is APB-style, always
// ready.

module tensor_grid_point_gather import tgpg_pkg::*; #(
   parameter int NODE_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   tgpg_req_if.sink            req_ch,
   tgpg_rsp_if.source          rsp_ch,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic                csr_pready
);

   localparam int AddrW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
   localparam bit IsPow2 = (NODE_DEPTH & (NODE_DEPTH - 1)) == 0;
   localparam logic [DivisorW-1:0] DepthWide = DivisorW'(NODE_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DSTART = 6'b000010,
      S_DIV    = 6'b000100,
      S_ADDR   = 6'b001000,
      S_MOD    = 6'b010000,
      S_LOAD   = 6'b100000
   } state_type;

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [DimCntW-1:0] dims_ff, dims_in;
   logic [PointsW-1:0] points_ff [HwDims];
   logic [PointsW-1:0] points_in [HwDims];
   logic               csr_wr;
   reg_index_type      reg_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[CsrAddrW-1:2]);

   always_comb begin
      dims_in   = dims_ff;
      points_in = points_ff;
      if (csr_wr) begin
         unique case (reg_sel)
            REG_DIMS:    dims_in      = csr_pwdata[DimCntW-1:0];
            REG_POINTS0: points_in[0] = csr_pwdata[PointsW-1:0];
            REG_POINTS1: points_in[1] = csr_pwdata[PointsW-1:0];
            REG_POINTS2: points_in[2] = csr_pwdata[PointsW-1:0];
            REG_POINTS3: points_in[3] = csr_pwdata[PointsW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_DIMS:    csr_prdata = CsrDataW'(dims_ff);
         REG_POINTS0: csr_prdata = CsrDataW'(points_ff[0]);
         REG_POINTS1: csr_prdata = CsrDataW'(points_ff[1]);
         REG_POINTS2: csr_prdata = CsrDataW'(points_ff[2]);
         REG_POINTS3: csr_prdata = CsrDataW'(points_ff[3]);
         default:     csr_prdata = '0;
      endcase
   end

   // Effective grid shape after the zero and saturation rules.
   logic [DimCntW-1:0] ndim;
   logic [DimW-1:0]    last_dim;
   logic [PointsW-1:0] pts_eff [HwDims];

   assign ndim     = eff_dims(dims_ff);
   assign last_dim = DimW'(ndim - DimCntW'(1));

   always_comb begin
      for (int d = 0; d < HwDims; d++) begin
         pts_eff[d] = eff_points(points_ff[d]);
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequencer state and working registers
   // ---------------------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [DimW-1:0]      dim_ff, dim_in;
   logic [LinearW-1:0]   idx_ff, idx_in;
   logic [PointsW-1:0]   local_ff [HwDims];
   logic [PointsW-1:0]   local_in [HwDims];
   logic [OffsetW-1:0]   offset_ff, offset_in;
   logic                 err_ff, err_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DimW-1:0]      rsp_dim_ff, rsp_dim_in;
   logic [CoordW-1:0]    rsp_coord_ff, rsp_coord_in;
   logic [LocalW-1:0]    rsp_local_ff, rsp_local_in;
   logic                 rsp_err_ff, rsp_err_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [CoordW-1:0]    node_mem_ff [NODE_DEPTH];
   logic [CoordW-1:0]    rdata_ff;

   div_req_type          div_req;
   div_status_type       div_st;

   logic                 req_accept;
   logic [LocalW-1:0]    req_idx [HwDims];
   logic                 multi_bad;
   logic [PointsW-1:0]   pts_cur;
   logic [DivisorW-1:0]  sum_wide;
   logic [DivisorW-1:0]  wr_wide;
   logic                 wr_in_range;
   logic                 wr_en;
   logic                 rd_en;
   logic [AddrW-1:0]     rd_addr;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign req_idx[0] = req_ch.index_dim0;
   assign req_idx[1] = req_ch.index_dim1;
   assign req_idx[2] = req_ch.index_dim2;
   assign req_idx[3] = req_ch.index_dim3;

   // A multiindex is rejected when any used dimension's index reaches its point count.
   always_comb begin
      multi_bad = 1'b0;
      for (int d = 0; d < HwDims; d++) begin
         if ((DimCntW'(d) < ndim) && ({1'b0, req_idx[d]} >= pts_eff[d])) begin
            multi_bad = 1'b1;
         end
      end
   end

   assign pts_cur     = pts_eff[dim_ff];
   assign sum_wide    = DivisorW'(offset_ff) + DivisorW'(local_ff[dim_ff]);
   assign wr_wide     = DivisorW'(req_ch.node_address);
   assign wr_in_range = wr_wide < DepthWide;

   // The table address wraps at the table depth: a mask for a power-of-two depth,
   // otherwise the remainder left by the shared divider.
   assign rd_addr = IsPow2 ? sum_wide[AddrW-1:0] : div_st.remainder[AddrW-1:0];

   always_comb begin
      state_in     = state_ff;
      dim_in       = dim_ff;
      idx_in       = idx_ff;
      local_in     = local_ff;
      offset_in    = offset_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dim_in   = rsp_dim_ff;
      rsp_coord_in = rsp_coord_ff;
      rsp_local_in = rsp_local_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      div_req.start    = 1'b0;
      div_req.dividend = idx_ff;
      div_req.divisor  = DivisorW'(pts_cur);
      wr_en = 1'b0;
      rd_en = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (mode_type'(req_ch.mode))
                  MODE_WRITE: wr_en = wr_in_range;
                  MODE_LINEAR: begin
                     idx_in   = req_ch.linear_index;
                     dim_in   = '0;
                     err_in   = 1'b0;
                     state_in = S_DSTART;
                  end
                  MODE_MULTI: begin
                     for (int d = 0; d < HwDims; d++) begin
                        local_in[d] = PointsW'(req_idx[d]);
                     end
                     dim_in    = '0;
                     offset_in = '0;
                     err_in    = multi_bad;
                     state_in  = multi_bad ? S_LOAD : S_ADDR;
                  end
                  default: ;
               endcase
            end
         end
         S_DSTART: begin
            div_req.start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (div_st.done) begin
               local_in[dim_ff] = div_st.remainder[PointsW-1:0];
               idx_in           = div_st.quotient;
               if (dim_ff == last_dim) begin
                  // A quotient left over after the top dimension means the flat
                  // index lies at or beyond the grid size.
                  if (div_st.quotient != '0) begin
                     err_in   = 1'b1;
                     state_in = S_LOAD;
                  end else begin
                     dim_in    = '0;
                     offset_in = '0;
                     state_in  = S_ADDR;
                  end
               end else begin
                  dim_in   = dim_ff + DimW'(1);
                  state_in = S_DSTART;
               end
            end
         end
         S_ADDR: begin
            if (IsPow2) begin
               rd_en    = 1'b1;
               state_in = S_LOAD;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DividendW'(sum_wide);
               div_req.divisor  = DepthWide;
               state_in         = S_MOD;
            end
         end
         S_MOD: begin
            if (div_st.done) begin
               rd_en    = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_dim_in   = '0;
                  rsp_coord_in = '0;
                  rsp_local_in = '0;
                  rsp_err_in   = 1'b1;
                  rsp_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  rsp_dim_in   = dim_ff;
                  rsp_coord_in = rdata_ff;
                  rsp_local_in = local_ff[dim_ff][LocalW-1:0];
                  rsp_err_in   = 1'b0;
                  rsp_last_in  = (dim_ff == last_dim);
                  offset_in    = offset_ff + OffsetW'(pts_cur);
                  if (dim_ff == last_dim) begin
                     state_in = S_IDLE;
                  end else begin
                     dim_in   = dim_ff + DimW'(1);
                     state_in = S_ADDR;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   tgpg_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .status (div_st)
   );

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dims_ff      <= DimCntW'(1);
         for (int d = 0; d < HwDims; d++) begin
            points_ff[d] <= PointsW'(1);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dims_ff      <= dims_in;
         points_ff    <= points_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      dim_ff       <= dim_in;
      idx_ff       <= idx_in;
      local_ff     <= local_in;
      offset_ff    <= offset_in;
      err_ff       <= err_in;
      rsp_dim_ff   <= rsp_dim_in;
      rsp_coord_ff <= rsp_coord_in;
      rsp_local_ff <= rsp_local_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Node table: one write port for write items, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) node_mem_ff[wr_wide[AddrW-1:0]] <= req_ch.node_value;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= node_mem_ff[rd_addr];
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.dimension   = rsp_dim_ff;
   assign rsp_ch.coordinate  = rsp_coord_ff;
   assign rsp_ch.local_index = rsp_local_ff;
   assign rsp_ch.error       = rsp_err_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

### sv/tgpg_checker.sv
// Port-level checks of the tensor grid point gather, attached by a bind statement.
// Depends on tgpg_pkg and the top level tensor_grid_point_gather.

module tgpg_checker import tgpg_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [ModeW-1:0]  req_mode,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DimW-1:0]   rsp_dimension,
   input logic [CoordW-1:0] rsp_coordinate,
   input logic [LocalW-1:0] rsp_local_index,
   input logic              rsp_error,
   input logic              rsp_last
);

   logic req_fire;
   logic is_lookup;

   assign req_fire  = req_valid && req_ready;
   assign is_lookup = (req_mode == MODE_LINEAR) || (req_mode == MODE_MULTI);

   // A stalled result stays offered with its coordinate and last flag unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coordinate) && $stable(rsp_last))
      else $error("stalled result changed or dropped");

   // A lookup occupies the block: no new item is taken in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && is_lookup |=> !req_ready)
      else $error("item accepted right after a lookup");

   // Write and unused items finish at once and leave the input ready.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_lookup |=> req_ready)
      else $error("write item stalled the input");

   // An error result is a lone, all-zero closing result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && (rsp_dimension == '0) &&
                                 (rsp_coordinate == '0) && (rsp_local_index == '0))
      else $error("malformed error result");

   // No result is offered right out of reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind tensor_grid_point_gather tgpg_checker u_tgpg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_mode        (req_ch.mode),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_dimension   (rsp_ch.dimension),
   .rsp_coordinate  (rsp_ch.coordinate),
   .rsp_local_index (rsp_ch.local_index),
   .rsp_error       (rsp_ch.error),
   .rsp_last        (rsp_ch.last)
);
